// ===== design/cp1251_pkg.sv =====
// shared types, constants and the byte encoder for the cp1251 to utf-8 transcoder
`timescale 1ns / 1ps

package cp1251_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned MAX_BYTES = 3;
    localparam int unsigned IDX_W     = 2;

    localparam logic [7:0]  ASCII_LIMIT = 8'h80;
    localparam logic [7:0]  CYR_BASE_BYTE = 8'hC0;
    localparam logic [15:0] CYR_BASE_CP = 16'h0410;
    localparam logic [15:0] TWO_BYTE_LIMIT = 16'h0800;
    localparam logic [7:0]  LEAD2_MARK = 8'hC0;
    localparam logic [7:0]  LEAD3_MARK = 8'hE0;
    localparam logic [7:0]  CONT_MARK = 8'h80;

    typedef logic [MAX_BYTES-1:0][BYTE_W-1:0] enc_bytes_t;

    typedef struct packed {
        enc_bytes_t       bytes;
        logic [IDX_W-1:0] last_idx;
    } enc_t;

    // code points for bytes 0x80 to 0xbf
    function automatic logic [15:0] hi_code(input logic [5:0] idx);
        logic [15:0] cp;
        case (idx)
            6'd0:  cp = 16'h0402;
            6'd1:  cp = 16'h0403;
            6'd2:  cp = 16'h201A;
            6'd3:  cp = 16'h0453;
            6'd4:  cp = 16'h201E;
            6'd5:  cp = 16'h2026;
            6'd6:  cp = 16'h2020;
            6'd7:  cp = 16'h2021;
            6'd8:  cp = 16'h20AC;
            6'd9:  cp = 16'h2030;
            6'd10: cp = 16'h0409;
            6'd11: cp = 16'h2039;
            6'd12: cp = 16'h040A;
            6'd13: cp = 16'h040C;
            6'd14: cp = 16'h040B;
            6'd15: cp = 16'h040F;
            6'd16: cp = 16'h0452;
            6'd17: cp = 16'h2018;
            6'd18: cp = 16'h2019;
            6'd19: cp = 16'h201C;
            6'd20: cp = 16'h201D;
            6'd21: cp = 16'h2022;
            6'd22: cp = 16'h2013;
            6'd23: cp = 16'h2014;
            6'd24: cp = 16'h0098;
            6'd25: cp = 16'h2122;
            6'd26: cp = 16'h0459;
            6'd27: cp = 16'h203A;
            6'd28: cp = 16'h045A;
            6'd29: cp = 16'h045C;
            6'd30: cp = 16'h045B;
            6'd31: cp = 16'h045F;
            6'd32: cp = 16'h00A0;
            6'd33: cp = 16'h040E;
            6'd34: cp = 16'h045E;
            6'd35: cp = 16'h0408;
            6'd36: cp = 16'h00A4;
            6'd37: cp = 16'h0490;
            6'd38: cp = 16'h00A6;
            6'd39: cp = 16'h00A7;
            6'd40: cp = 16'h0401;
            6'd41: cp = 16'h00A9;
            6'd42: cp = 16'h0404;
            6'd43: cp = 16'h00AB;
            6'd44: cp = 16'h00AC;
            6'd45: cp = 16'h00AD;
            6'd46: cp = 16'h00AE;
            6'd47: cp = 16'h0407;
            6'd48: cp = 16'h00B0;
            6'd49: cp = 16'h00B1;
            6'd50: cp = 16'h0406;
            6'd51: cp = 16'h0456;
            6'd52: cp = 16'h0491;
            6'd53: cp = 16'h00B5;
            6'd54: cp = 16'h00B6;
            6'd55: cp = 16'h00B7;
            6'd56: cp = 16'h0451;
            6'd57: cp = 16'h2116;
            6'd58: cp = 16'h0454;
            6'd59: cp = 16'h00BB;
            6'd60: cp = 16'h0458;
            6'd61: cp = 16'h0405;
            6'd62: cp = 16'h0455;
            6'd63: cp = 16'h0457;
            default: cp = 16'h0000;
        endcase
        return cp;
    endfunction

    function automatic enc_t encode(input logic [7:0] b, input logic enable);
        enc_t        e;
        logic [15:0] cp;
        e.bytes    = '0;
        e.last_idx = '0;
        if (b < ASCII_LIMIT) begin
            cp = {8'h00, b};
        end
        else if (b >= CYR_BASE_BYTE) begin
            cp = CYR_BASE_CP + {10'd0, b[5:0]};
        end
        else begin
            cp = hi_code(b[5:0]);
        end
        if (!enable || cp < {8'h00, ASCII_LIMIT}) begin
            e.bytes[0] = b;
            e.last_idx = 2'd0;
        end
        else if (cp < TWO_BYTE_LIMIT) begin
            e.bytes[0] = LEAD2_MARK | {3'b000, cp[10:6]};
            e.bytes[1] = CONT_MARK | {2'b00, cp[5:0]};
            e.last_idx = 2'd1;
        end
        else begin
            e.bytes[0] = LEAD3_MARK | {4'h0, cp[15:12]};
            e.bytes[1] = CONT_MARK | {2'b00, cp[11:6]};
            e.bytes[2] = CONT_MARK | {2'b00, cp[5:0]};
            e.last_idx = 2'd2;
        end
        return e;
    endfunction

endpackage

// ===== design/cp1251_in_if.sv =====
// input channel carrying one cp1251 byte per item
`timescale 1ns / 1ps

interface cp1251_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink (input valid, input in_byte, output ready);
endinterface

// ===== design/cp1251_out_if.sv =====
// output channel carrying one utf-8 byte per item
`timescale 1ns / 1ps

interface cp1251_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_char;

    modport source (output valid, output out_byte, output last_of_char, input ready);
    modport sink (input valid, input out_byte, input last_of_char, output ready);
endinterface

// ===== design/cp1251_to_utf8_transcoder_top.sv =====
// cp1251 to utf-8 transcoder top level
//
// in_ch takes one cp1251 byte per item, out_ch gives one utf-8 byte per item,
// lead byte first, with last_of_char set on the final byte of each character.
// cfg_write_en / cfg_write_data write convert_enable (reset 1); with it at 0
// every byte passes through as one item marked last. write it only when idle.
// an accepted byte is held in the input register, then is encoded into the
// emit register, from which its output items leave.
// the emit register sends one byte per cycle while out_ch.ready is high, so a
// character takes one, two or three output items: ascii bytes stream at one
// per cycle, cyrillic letters take two items, three-byte symbols three.
// the input register keeps taking a byte while the emit register still holds
// one, and refills the emit register on the same edge its last byte leaves.
// when out_ch.ready is low the emit register holds its byte, then the input
// register fills and in_ch.ready drops. reset empties both registers.
`timescale 1ns / 1ps

module cp1251_to_utf8_transcoder_top
(
    input  logic                clk,
    input  logic                rst_n,
    cp1251_in_if.sink           in_ch,
    cp1251_out_if.source        out_ch,
    input  logic                cfg_write_en,
    input  logic                cfg_write_data
);

    logic                         enable_reg;
    logic                         a_valid_reg;
    logic [7:0]                   a_byte_reg;
    logic                         b_valid_reg;
    cp1251_pkg::enc_bytes_t       b_bytes_reg;
    logic [cp1251_pkg::IDX_W-1:0] b_last_reg;
    logic [cp1251_pkg::IDX_W-1:0] b_idx_reg;

    cp1251_pkg::enc_t             enc;
    logic                         b_last_now;
    logic                         b_done;
    logic                         b_load;
    logic                         in_take;

    always_comb
    begin
        enc        = cp1251_pkg::encode(a_byte_reg, enable_reg);
        b_last_now = (b_idx_reg == b_last_reg);
        b_done     = b_valid_reg && out_ch.ready && b_last_now;
        b_load     = a_valid_reg && (!b_valid_reg || b_done);
        in_take    = in_ch.valid && in_ch.ready;
    end

    assign in_ch.ready         = !a_valid_reg || b_load;
    assign out_ch.valid        = b_valid_reg;
    assign out_ch.out_byte     = b_bytes_reg[b_idx_reg];
    assign out_ch.last_of_char = b_last_now;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg  <= 1'b1;
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            b_idx_reg   <= '0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                enable_reg <= cfg_write_data;
            end
            if (in_take)
            begin
                a_valid_reg <= 1'b1;
            end
            else if (b_load)
            begin
                a_valid_reg <= 1'b0;
            end
            if (b_load)
            begin
                b_valid_reg <= 1'b1;
                b_idx_reg   <= '0;
            end
            else if (b_done)
            begin
                b_valid_reg <= 1'b0;
                b_idx_reg   <= '0;
            end
            else if (b_valid_reg && out_ch.ready)
            begin
                b_idx_reg <= b_idx_reg + 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            a_byte_reg <= in_ch.in_byte;
        end
        if (b_load)
        begin
            b_bytes_reg <= enc.bytes;
            b_last_reg  <= enc.last_idx;
        end
    end

endmodule
